// ===== design/ssph_pkg.sv =====
package ssph_pkg;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               first;
		logic               last;
	} in_req_t;

	typedef struct packed {
		logic [31:0] total_matches;
		logic [31:0] new_matches;
		logic        table_full;
		logic        done_res;
	} out_req_t;

	// one table slot: used flag, key, occurrence count
	typedef struct packed {
		logic        used;
		logic [31:0] key;
		logic [31:0] count;
	} slot_t;

	typedef enum logic [7:0] {
		S_CLR    = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_SEED   = 8'b0000_0100,
		S_HOME_L = 8'b0000_1000,
		S_CHK_L  = 8'b0001_0000,
		S_HOME_B = 8'b0010_0000,
		S_CHK_B  = 8'b0100_0000,
		S_PUSH   = 8'b1000_0000
	} state_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== design/ssph_home.sv =====
// home slot = |key| mod TABLE_SIZE; mask for powers of two, else restoring
// remainder four bits per cycle
module ssph_home import ssph_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] home
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

	logic [31:0] mag;
	assign mag = key[31] ? (32'd0 - key) : key;

	generate
		if (POW2) begin : g_mask
			logic          done_q;
			logic [AW-1:0] home_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= mag[AW-1:0];
				end
			end
			assign done = done_q;
			assign home = home_q;
		end else begin : g_div
			localparam int RW = AW + 1;
			logic          busy_q;
			logic          done_q;
			logic [2:0]    cnt_q;
			logic [31:0]   sh_q;
			logic [RW-1:0] rem_q;
			logic [RW-1:0] rem_d;

			// four compare-and-subtract steps per cycle, MSB first
			always_comb begin
				rem_d = rem_q;
				for (int b = 0; b < 4; b++) begin
					rem_d = {rem_d[RW-2:0], sh_q[31 - b]};
					if (rem_d >= RW'(TABLE_SIZE)) begin
						rem_d = rem_d - RW'(TABLE_SIZE);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end else if (busy_q) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd7) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end
			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= mag;
					rem_q <= '0;
				end else if (busy_q) begin
					sh_q  <= {sh_q[27:0], 4'd0};
					rem_q <= rem_d;
				end
			end
			assign done = done_q;
			assign home = rem_q[AW-1:0];
		end
	endgenerate
endmodule

// ===== design/ssph_table.sv =====
// single-port-write, single-port-read table, registered read
module ssph_table import ssph_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(TABLE_SIZE)-1:0] waddr,
	input  slot_t                         wdata,
	input  logic [$clog2(TABLE_SIZE)-1:0] raddr,
	output slot_t                         rdata
);
	slot_t mem [TABLE_SIZE];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/subarray_sum_prefix_hash_counter.sv =====
// Flow from request accept to out_valid: S_HOME_L hashes the lookup key, S_CHK_L probes
// its chain, S_HOME_B hashes the insert key, S_CHK_B probes and writes, S_PUSH outputs.
// A first-marked request adds a table sweep (S_CLR) and seed (S_SEED) before the lookup.
// One request in flight: the next request is taken once the last result leaves S_PUSH,
// later while the previous result waits on out_ready.
// Async reset (arst_n low) clears control; a sweep in S_CLR then empties the table.
module subarray_sum_prefix_hash_counter import ssph_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_data
);
	localparam int AW = $clog2(TABLE_SIZE);
	localparam int PW = $clog2(TABLE_SIZE + 1);

	state_t        state_q, state_d;
	logic [31:0]   tgt_q;
	logic [31:0]   sum_q;      // running prefix
	logic [31:0]   tot_q;      // saturating match total
	logic [31:0]   found_q;    // matches ending at this request
	logic          full_q;     // sticky table-full flag
	logic          last_q;
	logic          seed_q;     // sweep was started by a first-marked request
	logic          go_q;       // kick the hash unit on entry to a home state
	logic [AW-1:0] clr_q;
	logic [AW-1:0] slot_q;     // slot whose data is on rdata
	logic [PW-1:0] probe_q;
	out_req_t      out_q;
	logic          out_valid_q;

	logic [31:0]   cur_key;
	logic          lphase;
	logic          h_start, h_done;
	logic [AW-1:0] h_home;
	logic          t_we;
	logic [AW-1:0] t_waddr, t_raddr, slot_nx;
	slot_t         t_wdata, t_rdata;
	logic          hit, empty, last_probe;
	logic          accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign lphase   = (state_q == S_HOME_L) || (state_q == S_CHK_L);
	// lookup key is prefix - target, insert key is the prefix itself
	assign cur_key  = lphase ? (sum_q - tgt_q) : sum_q;
	assign h_start  = go_q && ((state_q == S_HOME_L) || (state_q == S_HOME_B));

	assign slot_nx    = (slot_q == AW'(TABLE_SIZE - 1)) ? '0 : slot_q + 1'b1;
	assign empty      = !t_rdata.used;
	assign hit        = t_rdata.used && (t_rdata.key == cur_key);
	assign last_probe = (probe_q == PW'(TABLE_SIZE - 1));

	ssph_home #(.TABLE_SIZE(TABLE_SIZE)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.key    (cur_key),
		.done   (h_done),
		.home   (h_home)
	);

	ssph_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// next state, table port control
	always_comb begin
		state_d = state_q;
		t_we    = 1'b0;
		t_waddr = slot_q;
		t_wdata = '0;
		t_raddr = slot_q;
		unique case (state_q)
			S_CLR: begin
				t_we    = 1'b1;
				t_waddr = clr_q;
				if (clr_q == AW'(TABLE_SIZE - 1)) begin
					state_d = seed_q ? S_SEED : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = in_data.first ? S_CLR : S_HOME_L;
				end
			end
			S_SEED: begin
				// empty table: key 0 lands in its home slot 0
				t_we    = 1'b1;
				t_waddr = '0;
				t_wdata = '{used: 1'b1, key: 32'd0, count: 32'd1};
				state_d = S_HOME_L;
			end
			S_HOME_L, S_HOME_B: begin
				if (h_done) begin
					t_raddr = h_home;
					state_d = (state_q == S_HOME_L) ? S_CHK_L : S_CHK_B;
				end
			end
			S_CHK_L: begin
				if (empty || hit || last_probe) begin
					state_d = S_HOME_B;
				end else begin
					t_raddr = slot_nx;
				end
			end
			S_CHK_B: begin
				if (empty) begin
					t_we    = 1'b1;
					t_wdata = '{used: 1'b1, key: cur_key, count: 32'd1};
					state_d = S_PUSH;
				end else if (hit) begin
					t_we    = 1'b1;
					t_wdata = '{used: 1'b1, key: cur_key,
						count: sat_add(t_rdata.count, 32'd1)};
					state_d = S_PUSH;
				end else if (last_probe) begin
					state_d = S_PUSH;
				end else begin
					t_raddr = slot_nx;
				end
			end
			S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			seed_q      <= 1'b0;
			go_q        <= 1'b0;
			tgt_q       <= '0;
			sum_q       <= '0;
			tot_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= ((state_d == S_HOME_L) && (state_q != S_HOME_L))
				|| ((state_d == S_HOME_B) && (state_q != S_HOME_B));
			if (cfg_we) begin
				tgt_q <= cfg_wdata;
			end
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				seed_q <= in_data.first;
				clr_q  <= '0;
				if (in_data.first) begin
					sum_q  <= {{16{in_data.sample[15]}}, in_data.sample};
					tot_q  <= '0;
					full_q <= 1'b0;
				end else begin
					sum_q <= sum_q + {{16{in_data.sample[15]}}, in_data.sample};
				end
			end
			if ((state_q == S_CHK_L) && (empty || hit || last_probe)) begin
				tot_q <= sat_add(tot_q, hit ? t_rdata.count : 32'd0);
			end
			if ((state_q == S_CHK_B) && !empty && !hit && last_probe) begin
				full_q <= 1'b1;
			end
			// a new result replaces one taken this cycle
			if ((state_q == S_PUSH) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= in_data.last;
		end
		if ((state_q == S_HOME_L) || (state_q == S_HOME_B)) begin
			probe_q <= '0;
			slot_q  <= h_home;
		end else if ((state_q == S_CHK_L) || (state_q == S_CHK_B)) begin
			probe_q <= probe_q + 1'b1;
			slot_q  <= slot_nx;
		end
		if ((state_q == S_CHK_L) && (empty || hit || last_probe)) begin
			found_q <= hit ? t_rdata.count : 32'd0;
		end
		if ((state_q == S_PUSH) && (!out_valid_q || out_ready)) begin
			out_q <= '{total_matches: tot_q, new_matches: found_q,
				table_full: full_q, done_res: last_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== design/ssph_check.sv =====
module ssph_check import ssph_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input out_req_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.new_matches <= out_data.total_matches)
		else $error("new matches exceed total");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
endmodule

bind subarray_sum_prefix_hash_counter ssph_check u_ssph_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
